// File: design/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Types, codes and helpers shared by the WebSocket frame deframer modules.
// ----------------------------------------------------------------------------
package wsd_pkg;

    typedef enum logic [5:0] {
        PH_FIRST   = 6'b000001,
        PH_SECOND  = 6'b000010,
        PH_EXT_HI  = 6'b000100,
        PH_EXT_LO  = 6'b001000,
        PH_KEY     = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } t_phase;

    localparam logic       KIND_HEADER  = 1'b0;
    localparam logic       KIND_PAYLOAD = 1'b1;

    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [2:0] CLASS_TEXT  = 3'd0;
    localparam logic [2:0] CLASS_CLOSE = 3'd1;
    localparam logic [2:0] CLASS_PING  = 3'd2;
    localparam logic [2:0] CLASS_PONG  = 3'd3;
    localparam logic [2:0] CLASS_OTHER = 3'd4;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_LONG  = 7'd127;

    typedef struct packed {
        logic        event_kind;
        logic [3:0]  frame_opcode;
        logic [2:0]  frame_class;
        logic        masked_frame;
        logic [15:0] payload_length;
        logic [7:0]  payload_byte;
        logic        last;
        logic        long_form;
    } t_result;

    function automatic logic [2:0] class_of(input logic [3:0] op);
        logic [2:0] c;
        unique case (op)
            OP_TEXT:  c = CLASS_TEXT;
            OP_CLOSE: c = CLASS_CLOSE;
            OP_PING:  c = CLASS_PING;
            OP_PONG:  c = CLASS_PONG;
            default:  c = CLASS_OTHER;
        endcase
        return c;
    endfunction

endpackage

// File: design/wsd_parser.sv
// ----------------------------------------------------------------------------
// wsd_parser
// Header/payload FSM: one byte in per i_accept, at most one result out per cycle.
// ----------------------------------------------------------------------------
module wsd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    output logic             o_push,
    output wsd_pkg::t_result o_result
);
    import wsd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_mask, n_mask;
    logic        r_long, n_long;
    logic [15:0] r_length, n_length;
    logic [15:0] r_remaining, n_remaining;
    logic [1:0]  r_key_index, n_key_index;
    logic [7:0]  r_key [4];

    logic        produce;
    logic        res_kind;
    logic [7:0]  res_byte;
    logic        res_last;
    logic [15:0] rem_dec;

    assign rem_dec = r_remaining - 16'd1;

    always_comb begin
        n_phase     = r_phase;
        n_opcode    = r_opcode;
        n_mask      = r_mask;
        n_long      = r_long;
        n_length    = r_length;
        n_remaining = r_remaining;
        n_key_index = r_key_index;
        produce     = 1'b0;
        res_kind    = KIND_HEADER;
        res_byte    = 8'd0;
        res_last    = 1'b0;
        unique case (r_phase)
            PH_SECOND: begin
                n_mask      = i_data_byte[7];
                n_long      = (i_data_byte[6:0] == LEN_LONG);
                n_length    = {9'd0, i_data_byte[6:0]};
                n_key_index = 2'd0;
                if (i_data_byte[6:0] == LEN_EXT16) begin
                    n_phase = PH_EXT_HI;
                end else if (i_data_byte[7]) begin
                    n_phase = PH_KEY;
                end else begin
                    produce = 1'b1;
                end
            end
            PH_EXT_HI: begin
                n_length = {i_data_byte, 8'd0};
                n_phase  = PH_EXT_LO;
            end
            PH_EXT_LO: begin
                n_length = {r_length[15:8], i_data_byte};
                if (r_mask) begin
                    n_phase     = PH_KEY;
                    n_key_index = 2'd0;
                end else begin
                    produce = 1'b1;
                end
            end
            PH_KEY: begin
                n_key_index = r_key_index + 2'd1;
                if (r_key_index == 2'd3) begin
                    produce = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                produce     = 1'b1;
                res_kind    = KIND_PAYLOAD;
                res_byte    = r_mask ? (i_data_byte ^ r_key[r_key_index]) : i_data_byte;
                n_key_index = r_key_index + 2'd1;
                n_remaining = rem_dec;
                res_last    = (rem_dec == 16'd0);
                if (res_last) begin
                    n_phase = PH_FIRST;
                end
            end
            default: begin
                n_opcode = i_data_byte[3:0];
                n_phase  = PH_SECOND;
            end
        endcase
        // header completion: payload counter loaded, empty frames close at once
        if (produce && res_kind == KIND_HEADER) begin
            n_key_index = 2'd0;
            n_remaining = n_length;
            res_last    = (n_length == 16'd0);
            n_phase     = res_last ? PH_FIRST : PH_PAYLOAD;
        end
    end

    assign o_push = i_accept && produce;

    always_comb begin
        o_result.event_kind     = res_kind;
        o_result.frame_opcode   = n_opcode;
        o_result.frame_class    = class_of(n_opcode);
        o_result.masked_frame   = n_mask;
        o_result.payload_length = n_length;
        o_result.payload_byte   = res_byte;
        o_result.last           = res_last;
        o_result.long_form      = n_long;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FIRST;
            r_opcode    <= 4'd0;
            r_mask      <= 1'b0;
            r_long      <= 1'b0;
            r_length    <= 16'd0;
            r_remaining <= 16'd0;
            r_key_index <= 2'd0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_opcode    <= n_opcode;
            r_mask      <= n_mask;
            r_long      <= n_long;
            r_length    <= n_length;
            r_remaining <= n_remaining;
            r_key_index <= n_key_index;
        end
    end

    // masking key store, no reset: only read after all four bytes are written
    always_ff @(posedge i_clk) begin
        if (i_accept && r_phase == PH_KEY) begin
            r_key[r_key_index] <= i_data_byte;
        end
    end

    a_ext_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_phase == PH_SECOND && i_data_byte[6:0] == LEN_EXT16)
        |=> r_phase == PH_EXT_HI)
        else $error("extended length code did not enter EXT_HI");

    a_hdr_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_result.event_kind == KIND_HEADER) |=> r_key_index == 2'd0)
        else $error("key index not cleared at header completion");

    a_last_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_result.last) |=> r_phase == PH_FIRST)
        else $error("frame end did not return to first header byte");

endmodule

// File: design/wsd_out_buf.sv
// ----------------------------------------------------------------------------
// wsd_out_buf
// Result register with skid stage: one more item is taken while output stalls.
// ----------------------------------------------------------------------------
module wsd_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  wsd_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_valid,
    output logic             o_can_accept,
    output wsd_pkg::t_result o_result
);
    import wsd_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    take;

    assign take         = r_out_valid && i_ready;
    assign o_valid      = r_out_valid;
    assign o_result     = r_out;
    assign o_can_accept = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else if (!i_push) begin
                r_out_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_push) begin
                r_out <= i_result;
            end
        end else if (i_push) begin
            if (!r_out_valid) begin
                r_out <= i_result;
            end else begin
                r_skid <= i_result;
            end
        end
    end

    a_skid_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid item held with empty result register");

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("item pushed while skid stage full");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_ready) |=> (r_out_valid && r_out == $past(r_skid)))
        else $error("skid item not moved to result register");

endmodule

// File: design/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// WebSocket receive deframer: header decode, unmasking, header and byte results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready / i_data_byte) carries the raw stream,
//   one byte per item. Output channel (o_valid / i_ready / o_* fields) gives
//   one header result when a frame header is complete, then one result per
//   payload byte, unmasked, the final one with o_last set. Length code 127
//   is taken as a length of 127 with o_long_form set.
//   Throughput: one byte per cycle while i_ready is high, set by the parser
//   update feeding the result register. Each result is registered as its
//   byte is taken, into the result register or, on a stall, the skid entry.
//   Header bytes that complete nothing produce no result.
//   Stall: a result register plus one skid entry; o_ready drops only while
//   the skid entry is occupied, and no item is lost or repeated.
//   Reset (i_rst_n low, synchronous): parser waits for a first header byte,
//   output is empty. The masking key store is not cleared.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_event_kind,
    output logic [3:0]  o_frame_opcode,
    output logic [2:0]  o_frame_class,
    output logic        o_masked_frame,
    output logic [15:0] o_payload_length,
    output logic [7:0]  o_payload_byte,
    output logic        o_last,
    output logic        o_long_form
);
    import wsd_pkg::*;

    logic    accept;
    logic    push;
    logic    can_accept;
    t_result parsed;
    t_result result;

    assign o_ready = can_accept;
    assign accept  = i_valid && can_accept;

    wsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .o_push      (push),
        .o_result    (parsed)
    );

    wsd_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_result     (parsed),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_can_accept (can_accept),
        .o_result     (result)
    );

    assign o_event_kind     = result.event_kind;
    assign o_frame_opcode   = result.frame_opcode;
    assign o_frame_class    = result.frame_class;
    assign o_masked_frame   = result.masked_frame;
    assign o_payload_length = result.payload_length;
    assign o_payload_byte   = result.payload_byte;
    assign o_last           = result.last;
    assign o_long_form      = result.long_form;

endmodule
